### design/fpt_pkg.sv
// ----------------------------------------------------------------------------
// fpt_pkg
// Shared types and constants for the Fermat probable-prime tester: widths,
// reset value of the base register, modular operation codes and the
// command/status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fpt_pkg;

   // fixed widths of the ports
   localparam int CAND_WIDTH = 32;
   localparam int BASE_WIDTH = 32;

   // default number width used for the test
   localparam int NUM_WIDTH_DEF = 32;

   // witness base after reset
   localparam logic [BASE_WIDTH-1:0] BASE_RESET = 32'd11;

   // modular operations run on the shared multiplier
   typedef enum logic [1:0] {
      OP_BASE = 2'd0,   // base mod n
      OP_MUL  = 2'd1,   // acc * sq mod n
      OP_SQR  = 2'd2    // sq * sq mod n
   } op_type;

   // controller to datapath
   typedef struct packed {
      logic   load;         // capture a new candidate
      logic   start;        // launch one modular operation
      op_type op;           // which operation to launch
      logic   shift;        // drop the lowest exponent bit
      logic   result_load;  // capture the verdict
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic trivial;   // below four or even, answered without exponentiation
      logic e_zero;    // exponent fully consumed
      logic e_lsb;     // current exponent bit
      logic mul_done;  // modular operation finished
   } status_type;

endpackage

`default_nettype wire

### design/fermat_prime_test_top.sv
// ----------------------------------------------------------------------------
// fermat_prime_test_top
// Single-base Fermat probable-prime tester with a programmable witness base.
// ----------------------------------------------------------------------------
// One candidate is tested at a time; the low NUM_WIDTH bits of req_candidate
// are used. Values below two and even values other than two answer "not
// prime", two and three answer "prime". Any other candidate n is checked
// as base^n mod n == base mod n with LSB-first square-and-multiply on one
// shared bit-serial modular multiplier: one reduction of the base, then for
// each of the k significant bits of n a square and (on a one bit) a
// multiply. The next candidate is accepted as soon as the verdict is handed
// to the result register, even while that result still waits for
// rsp_ready.
// The base register (reset 11) is written through csr_valid/csr_fermat_base
// and must only be written while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module fermat_prime_test_top
   import fpt_pkg::*;
#(
   parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [CAND_WIDTH-1:0] req_candidate,
   // response channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_is_prime,
   // base register write
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [BASE_WIDTH-1:0] csr_fermat_base
);

   cmd_type    cmd;
   status_type status;

   // base writes always complete in one transfer
   assign csr_ready = 1'b1;

   fpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   fpt_datapath #(
      .NUM_WIDTH (NUM_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .candidate  (req_candidate),
      .base_write (csr_valid & csr_ready),
      .base_data  (csr_fermat_base),
      .is_prime   (rsp_is_prime)
   );

endmodule

`default_nettype wire

### design/fpt_mulmod.sv
// ----------------------------------------------------------------------------
// fpt_mulmod
// Iterative modular multiplier: x * y mod m, one bit of y per cycle from the
// top, by doubling and adding with reduction. Requires x < m and m >= 2.
// ----------------------------------------------------------------------------
`default_nettype none

module fpt_mulmod
   import fpt_pkg::*;
#(
   parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [NUM_WIDTH-1:0]  x,
   input  wire logic [BASE_WIDTH-1:0] y,
   input  wire logic [NUM_WIDTH-1:0]  m,
   output logic                       done,
   output logic [NUM_WIDTH-1:0]       product
);

   localparam int CNT_W = $clog2(BASE_WIDTH);

   logic                  busy_ff;
   logic                  done_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [NUM_WIDTH-1:0]  x_ff;
   logic [BASE_WIDTH-1:0] y_ff;
   logic [NUM_WIDTH-1:0]  m_ff;
   logic [NUM_WIDTH-1:0]  r_ff;
   logic [NUM_WIDTH-1:0]  r_in;

   logic [NUM_WIDTH-1:0]  x_sel;
   logic [NUM_WIDTH+1:0]  sum;
   logic [NUM_WIDTH+1:0]  m_one;
   logic [NUM_WIDTH+1:0]  m_two;
   logic [NUM_WIDTH+1:0]  diff_one;
   logic [NUM_WIDTH+1:0]  diff_two;

   // one step: r = 2r + bit*x, then bring back below m (sum < 3m)
   always_comb begin
      x_sel    = y_ff[BASE_WIDTH-1] ? x_ff : '0;
      sum      = {1'b0, r_ff, 1'b0} + {2'b00, x_sel};
      m_one    = {2'b00, m_ff};
      m_two    = {1'b0, m_ff, 1'b0};
      diff_one = sum - m_one;
      diff_two = sum - m_two;
      if (sum >= m_two) begin
         r_in = diff_two[NUM_WIDTH-1:0];
      end else if (sum >= m_one) begin
         r_in = diff_one[NUM_WIDTH-1:0];
      end else begin
         r_in = sum[NUM_WIDTH-1:0];
      end
   end

   // control of the iteration
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(BASE_WIDTH - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // operands and partial remainder
   always_ff @(posedge clock) begin
      if (start) begin
         x_ff <= x;
         y_ff <= y;
         m_ff <= m;
         r_ff <= '0;
      end else if (busy_ff) begin
         y_ff <= {y_ff[BASE_WIDTH-2:0], 1'b0};
         r_ff <= r_in;
      end
   end

   assign done    = done_ff;
   assign product = r_ff;

endmodule

`default_nettype wire

### design/fpt_datapath.sv
// ----------------------------------------------------------------------------
// fpt_datapath
// Holds the candidate, exponent, accumulator, running square, reduced base
// and base register, and the shared modular multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module fpt_datapath
   import fpt_pkg::*;
#(
   parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output status_type                 status,
   input  wire logic [CAND_WIDTH-1:0] candidate,
   input  wire logic                  base_write,
   input  wire logic [BASE_WIDTH-1:0] base_data,
   output logic                       is_prime
);

   logic [BASE_WIDTH-1:0] base_ff;
   logic [NUM_WIDTH-1:0]  n_ff;
   logic [NUM_WIDTH-1:0]  e_ff;
   logic [NUM_WIDTH-1:0]  acc_ff;
   logic [NUM_WIDTH-1:0]  sq_ff;
   logic [NUM_WIDTH-1:0]  amod_ff;
   op_type                op_ff;
   logic                  result_ff;

   logic [NUM_WIDTH-1:0]  mm_x;
   logic [BASE_WIDTH-1:0] mm_y;
   logic                  mm_done;
   logic [NUM_WIDTH-1:0]  mm_product;
   logic                  below_four;
   logic                  two_or_three;
   logic                  trivial_prime;
   logic                  result_in;

   // witness base register
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= BASE_RESET;
      end else if (base_write) begin
         base_ff <= base_data;
      end
   end

   // operand selection for the multiplier
   always_comb begin
      case (cmd.op)
         OP_BASE: begin
            mm_x = NUM_WIDTH'(1);
            mm_y = base_ff;
         end
         OP_MUL: begin
            mm_x = acc_ff;
            mm_y = BASE_WIDTH'(sq_ff);
         end
         OP_SQR: begin
            mm_x = sq_ff;
            mm_y = BASE_WIDTH'(sq_ff);
         end
         default: begin
            mm_x = sq_ff;
            mm_y = BASE_WIDTH'(sq_ff);
         end
      endcase
   end

   fpt_mulmod #(
      .NUM_WIDTH (NUM_WIDTH)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.start),
      .x       (mm_x),
      .y       (mm_y),
      .m       (n_ff),
      .done    (mm_done),
      .product (mm_product)
   );

   // candidate, exponent and running values
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         n_ff   <= candidate[NUM_WIDTH-1:0];
         e_ff   <= candidate[NUM_WIDTH-1:0];
         acc_ff <= NUM_WIDTH'(1);
      end else begin
         if (cmd.shift) begin
            e_ff <= {1'b0, e_ff[NUM_WIDTH-1:1]};
         end
         if (mm_done) begin
            case (op_ff)
               OP_BASE: begin
                  amod_ff <= mm_product;
                  sq_ff   <= mm_product;
               end
               OP_MUL:  acc_ff <= mm_product;
               OP_SQR:  sq_ff  <= mm_product;
               default: sq_ff  <= sq_ff;
            endcase
         end
      end
      if (cmd.start) begin
         op_ff <= cmd.op;
      end
   end

   // small and even candidates
   always_comb begin
      below_four    = (n_ff[NUM_WIDTH-1:2] == '0);
      two_or_three  = (n_ff[NUM_WIDTH-1:1] == (NUM_WIDTH-1)'(1));
      trivial_prime = two_or_three;
      result_in     = (below_four || !n_ff[0]) ? trivial_prime : (acc_ff == amod_ff);
   end

   // verdict register
   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         result_ff <= result_in;
      end
   end

   assign status.trivial  = below_four || !n_ff[0];
   assign status.e_zero   = (e_ff == '0);
   assign status.e_lsb    = e_ff[0];
   assign status.mul_done = mm_done;
   assign is_prime        = result_ff;

endmodule

`default_nettype wire

### design/fpt_ctrl.sv
// ----------------------------------------------------------------------------
// fpt_ctrl
// Sequencer for the test: accepts a candidate, settles small and even values
// at once, otherwise walks the exponent bits issuing multiply and square
// operations, then hands the verdict to the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fpt_ctrl
   import fpt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output cmd_type         cmd,
   input  wire status_type status
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_CHECK = 7'b0000010,
      ST_BASE  = 7'b0000100,
      ST_BIT   = 7'b0001000,
      ST_MUL   = 7'b0010000,
      ST_SQR   = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   // next state and commands
   always_comb begin
      state_in        = state_ff;
      cmd.load        = 1'b0;
      cmd.start       = 1'b0;
      cmd.op          = OP_SQR;
      cmd.shift       = 1'b0;
      cmd.result_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.trivial) begin
               state_in = ST_DONE;
            end else begin
               cmd.start = 1'b1;
               cmd.op    = OP_BASE;
               state_in  = ST_BASE;
            end
         end
         ST_BASE: begin
            if (status.mul_done) begin
               state_in = ST_BIT;
            end
         end
         ST_BIT: begin
            if (status.e_zero) begin
               state_in = ST_DONE;
            end else if (status.e_lsb) begin
               cmd.start = 1'b1;
               cmd.op    = OP_MUL;
               state_in  = ST_MUL;
            end else begin
               cmd.start = 1'b1;
               cmd.op    = OP_SQR;
               state_in  = ST_SQR;
            end
         end
         ST_MUL: begin
            if (status.mul_done) begin
               cmd.start = 1'b1;
               cmd.op    = OP_SQR;
               state_in  = ST_SQR;
            end
         end
         ST_SQR: begin
            if (status.mul_done) begin
               cmd.shift = 1'b1;
               state_in  = ST_BIT;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.result_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result valid: set on load, cleared on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.result_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire
